FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ACRMS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ACRMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/core/acrms_pkg.sv
// ----------------------------------------------------------------------------
// acrms_pkg
// Types, constants and controller/datapath interface structs of the AC
// true-RMS voltage meter.
// ----------------------------------------------------------------------------
`default_nettype none

package acrms_pkg;

  localparam int unsigned SAMPLE_W  = 13;
  localparam int unsigned VALUE_W   = 24;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned SENS_W    = 17;
  localparam int unsigned WIN_W     = 13;
  localparam int unsigned SQ_W      = 2 * SAMPLE_W;
  localparam int unsigned SUM_W     = 39;
  localparam int unsigned DIV_N     = SUM_W;
  localparam int unsigned DIV_M     = SENS_W;
  localparam int unsigned ROOT_W    = (DIV_N + DIV_N % 2) / 2;
  localparam int unsigned PROD_W    = ROOT_W + SENS_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_WINDOW_DEF  = 4096;
  localparam int unsigned CAL_SAMPLES_DEF = 50;

  localparam logic [SAMPLE_W-1:0] VALID_MAX_MV = 13'd5500;
  localparam logic [SAMPLE_W-1:0] ZERO_RESET   = 13'd2500;
  localparam logic [SENS_W-1:0]   SENS_RESET   = 17'd1000;
  localparam logic [WIN_W-1:0]    WIN_RESET    = 13'd1000;
  localparam logic [SENS_W-1:0]   RMS_SCALE    = 17'd100000;
  localparam logic [VALUE_W-1:0]  VALUE_MAX    = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO = 2'd0,
    CFG_SENS = 2'd1,
    CFG_WIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_CAL  = 2'd0,
    KIND_RMS  = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIV_CAL   = 2'd0,
    DIV_MEAN  = 2'd1,
    DIV_SCALE = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_CAL_DIV,
    ST_MEAN_DIV,
    ST_ROOT,
    ST_SCALE,
    ST_RMS_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_mv;
    logic                source_valid;
  } in_t;

  typedef struct packed {
    kind_e              result_kind;
    logic [VALUE_W-1:0] value_mv;
    logic [COUNT_W-1:0] valid_count;
  } out_t;

  typedef struct packed {
    logic     load_sample;
    logic     accumulate;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     mul_load;
    logic     set_cal;
    logic     set_fail;
    logic     set_rms;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic calibrating;
    logic cal_done;
    logic cal_any;
    logic win_done;
    logic win_fail;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ac_true_rms_voltage_meter.sv
// ----------------------------------------------------------------------------
// ac_true_rms_voltage_meter
// True-RMS mains voltage meter working on converter samples in millivolts.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one sample per
// transfer. An ordinary sample goes through the register, accumulate and
// check states before the block takes a new sample.
// The first CAL_SAMPLES samples set the zero point; the last one of them
// yields a calibration result, after a divide when one is needed.
// Later samples form windows; the last sample of a window yields an RMS or a
// failure result. The RMS path runs the shared serial divider twice and the
// serial root unit once, and in_stall_o stays high from transfer to result.
// Output channel (out_valid_o / out_stall_i / out_data_o): a one-entry output
// register; the block keeps taking samples while a result waits, and holds
// a new result in staging until the register is free.
// Configuration (cfg_valid_i / cfg_ready_o): always ready, write when idle.
// Reset restores register defaults and restarts calibration.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ac_true_rms_voltage_meter #(
  parameter int unsigned MAX_WINDOW  = acrms_pkg::MAX_WINDOW_DEF,
  parameter int unsigned CAL_SAMPLES = acrms_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire acrms_pkg::in_t                    in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output acrms_pkg::out_t                        out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [acrms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [acrms_pkg::SENS_W-1:0]      cfg_data_i
);

  import acrms_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  acrms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  acrms_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `ACRMS_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ACRMS_ASSERT_IMP(a_kind_known, clk_i, rst_ni, out_valid_o, out_data_o.result_kind == KIND_CAL || out_data_o.result_kind == KIND_RMS || out_data_o.result_kind == KIND_FAIL)
  `ACRMS_ASSERT_IMP(a_fail_value_zero, clk_i, rst_ni, out_valid_o && out_data_o.result_kind == KIND_FAIL, out_data_o.value_mv == '0)
  `ACRMS_ASSERT_IMP(a_cal_value_fits, clk_i, rst_ni, out_valid_o && out_data_o.result_kind == KIND_CAL, out_data_o.value_mv[VALUE_W-1:SAMPLE_W] == '0)

endmodule

`default_nettype wire

FILE: rtl/core/acrms_div.sv
// ----------------------------------------------------------------------------
// acrms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_div #(
  parameter int unsigned N = 39,
  parameter int unsigned M = 17
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [M-1:0] divisor_i,
  output logic              done_o,
  output logic [N-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N-1:0]     quo_q;
  logic [M-1:0]     rem_q;
  logic [M-1:0]     dvs_q;
  logic [M:0]       rem_sh;
  logic [M:0]       rem_sub;
  logic             take;

  always_comb begin
    rem_sh  = {rem_q, quo_q[N-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    take    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(N);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit in, keep the trial difference if it fits
      quo_q <= {quo_q[N-2:0], take};
      rem_q <= take ? rem_sub[M-1:0] : rem_sh[M-1:0];
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/acrms_sqrt.sv
// ----------------------------------------------------------------------------
// acrms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_sqrt #(
  parameter int unsigned IW = 39
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [IW-1:0]               radicand_i,
  output logic                             done_o,
  output logic [(IW + IW % 2) / 2 - 1:0]   root_o
);

  localparam int unsigned PW    = IW + IW % 2;
  localparam int unsigned QW    = PW / 2;
  localparam int unsigned RW    = QW + 3;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0]    rad_q;
  logic [RW-1:0]    rem_q;
  logic [QW-1:0]    root_q;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             take;

  always_comb begin
    rem_sh = {rem_q[RW-3:0], rad_q[PW-1:PW-2]};
    trial  = RW'({root_q, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= PW'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[PW-3:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[QW-2:0], take};
    end
  end

  assign done_o = !busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/core/acrms_ctrl.sv
// ----------------------------------------------------------------------------
// acrms_ctrl
// Sequencer: takes one sample, updates the running sums and walks the
// calibration or window-end arithmetic through the shared units.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire acrms_pkg::status_t  status_i,
  output acrms_pkg::cmd_t          cmd_o
);

  import acrms_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ACCUM;
      end
      ST_ACCUM: state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.calibrating) begin
          if (!status_i.cal_done)     state_d = ST_IDLE;
          else if (status_i.cal_any)  state_d = ST_CAL_DIV;
          else                        state_d = ST_EMIT;
        end else begin
          if (!status_i.win_done)     state_d = ST_IDLE;
          else if (status_i.win_fail) state_d = ST_EMIT;
          else                        state_d = ST_MEAN_DIV;
        end
      end
      ST_CAL_DIV: begin
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_MEAN_DIV: begin
        if (status_i.div_done) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.sqrt_done) state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_RMS_DIV;
      ST_RMS_DIV: begin
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:  cmd_o.load_sample = in_valid_i;
      ST_ACCUM: cmd_o.accumulate = 1'b1;
      ST_CHECK: begin
        if (status_i.calibrating) begin
          if (status_i.cal_done) begin
            if (status_i.cal_any) begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_CAL;
            end else begin
              cmd_o.set_cal = 1'b1;
            end
          end
        end else if (status_i.win_done) begin
          if (status_i.win_fail) begin
            cmd_o.set_fail = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_MEAN;
          end
        end
      end
      ST_CAL_DIV:  cmd_o.set_cal = status_i.div_done;
      ST_MEAN_DIV: cmd_o.sqrt_start = status_i.div_done;
      ST_ROOT:     cmd_o.mul_load = status_i.sqrt_done;
      ST_SCALE: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SCALE;
      end
      ST_RMS_DIV:  cmd_o.set_rms = status_i.div_done;
      ST_EMIT:     cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/acrms_dp.sv
// ----------------------------------------------------------------------------
// acrms_dp
// Datapath: configuration registers, calibration and window sums, the shared
// divider, the root unit, the scale multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_dp #(
  parameter int unsigned MAX_WINDOW  = acrms_pkg::MAX_WINDOW_DEF,
  parameter int unsigned CAL_SAMPLES = acrms_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_wr_i,
  input  wire logic [acrms_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [acrms_pkg::SENS_W-1:0]           cfg_data_i,
  input  wire acrms_pkg::in_t                         in_data_i,
  input  wire acrms_pkg::cmd_t                        cmd_i,
  output acrms_pkg::status_t                          status_o,
  input  wire logic                                   out_stall_i,
  output logic                                        out_valid_o,
  output acrms_pkg::out_t                             out_data_o
);

  import acrms_pkg::*;

  localparam int unsigned CW  = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned CSW = SAMPLE_W + CW;

  // configuration
  logic [SAMPLE_W-1:0] cfg_zero_q;
  logic [SENS_W-1:0]   cfg_sens_q;
  logic [WIN_W-1:0]    cfg_win_q;

  // running state
  logic                calibrating_q;
  logic [CW-1:0]       cal_index_q;
  logic [CSW-1:0]      cal_sum_q;
  logic [CW-1:0]       cal_valid_q;
  logic [SAMPLE_W-1:0] zero_q;
  logic [WIN_W-1:0]    win_index_q;
  logic [COUNT_W-1:0]  win_valid_q;
  logic [SUM_W-1:0]    sq_sum_q;

  // sample stage
  logic [SAMPLE_W-1:0] mv_q;
  logic                ok_q;
  logic [SQ_W-1:0]     sq_q;
  logic [SAMPLE_W-1:0] delta;
  logic [SQ_W-1:0]     sq;

  // arithmetic
  logic [DIV_N-1:0]    div_dividend;
  logic [DIV_M-1:0]    div_divisor;
  logic [DIV_N-1:0]    div_quo;
  logic                div_done;
  logic [ROOT_W-1:0]   root;
  logic                sqrt_done;
  logic [PROD_W-1:0]   prod_q;

  logic [WIN_W-1:0]    win_len;
  logic [SAMPLE_W-1:0] cal_zero;
  logic [VALUE_W-1:0]  rms_value;
  logic                rms_sat;

  out_t                res_q;
  logic                out_valid_q;
  out_t                out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_zero_q <= ZERO_RESET;
      cfg_sens_q <= SENS_RESET;
      cfg_win_q  <= WIN_RESET;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_ZERO: cfg_zero_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_SENS: cfg_sens_q <= cfg_data_i;
        CFG_WIN:  cfg_win_q  <= cfg_data_i[WIN_W-1:0];
        default:  ;
      endcase
    end
  end

  // effective window length: zero counts as one, clamp at the maximum
  always_comb begin
    win_len = cfg_win_q;
    if (cfg_win_q == '0) begin
      win_len = WIN_W'(1);
    end else if (32'(cfg_win_q) > 32'(MAX_WINDOW)) begin
      win_len = WIN_W'(MAX_WINDOW);
    end
  end

  always_comb begin
    delta = (in_data_i.sample_mv >= zero_q) ? (in_data_i.sample_mv - zero_q)
                                            : (zero_q - in_data_i.sample_mv);
    sq    = SQ_W'(delta) * SQ_W'(delta);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      mv_q <= in_data_i.sample_mv;
      ok_q <= in_data_i.source_valid && (in_data_i.sample_mv <= VALID_MAX_MV);
      sq_q <= sq;
    end
  end

  always_comb begin
    cal_zero  = (cal_valid_q != '0) ? div_quo[SAMPLE_W-1:0] : cfg_zero_q;
    rms_sat   = (cfg_sens_q == '0) || (|div_quo[DIV_N-1:VALUE_W]);
    rms_value = rms_sat ? VALUE_MAX : div_quo[VALUE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrating_q <= 1'b1;
      cal_index_q   <= '0;
      cal_sum_q     <= '0;
      cal_valid_q   <= '0;
      zero_q        <= ZERO_RESET;
      win_index_q   <= '0;
      win_valid_q   <= '0;
      sq_sum_q      <= '0;
    end else begin
      if (cmd_i.accumulate) begin
        if (calibrating_q) begin
          cal_index_q <= cal_index_q + CW'(1);
          if (ok_q) begin
            cal_sum_q   <= cal_sum_q + CSW'(mv_q);
            cal_valid_q <= cal_valid_q + CW'(1);
          end
        end else begin
          win_index_q <= win_index_q + WIN_W'(1);
          if (ok_q) begin
            sq_sum_q    <= sq_sum_q + SUM_W'(sq_q);
            win_valid_q <= win_valid_q + COUNT_W'(1);
          end
        end
      end
      if (cmd_i.set_cal) begin
        zero_q        <= cal_zero;
        calibrating_q <= 1'b0;
        cal_index_q   <= '0;
        cal_sum_q     <= '0;
        cal_valid_q   <= '0;
      end
      if (cmd_i.set_fail || cmd_i.set_rms) begin
        win_index_q <= '0;
        win_valid_q <= '0;
        sq_sum_q    <= '0;
      end
    end
  end

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd_i.div_sel)
      DIV_CAL: begin
        div_dividend = DIV_N'(cal_sum_q);
        div_divisor  = DIV_M'(cal_valid_q);
      end
      DIV_MEAN: begin
        div_dividend = sq_sum_q;
        div_divisor  = DIV_M'(win_valid_q);
      end
      DIV_SCALE: begin
        div_dividend = DIV_N'(prod_q);
        div_divisor  = cfg_sens_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  acrms_div #(
    .N (DIV_N),
    .M (DIV_M)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  acrms_sqrt #(
    .IW (DIV_N)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (div_quo),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= PROD_W'(root) * PROD_W'(RMS_SCALE);
    end
  end

  // result staging, ahead of the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_cal) begin
      res_q.result_kind <= KIND_CAL;
      res_q.value_mv    <= VALUE_W'(cal_zero);
      res_q.valid_count <= COUNT_W'(cal_valid_q);
    end else if (cmd_i.set_fail) begin
      res_q.result_kind <= KIND_FAIL;
      res_q.value_mv    <= '0;
      res_q.valid_count <= win_valid_q;
    end else if (cmd_i.set_rms) begin
      res_q.result_kind <= KIND_RMS;
      res_q.value_mv    <= rms_value;
      res_q.valid_count <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    status_o.calibrating = calibrating_q;
    status_o.cal_done    = (cal_index_q == CW'(CAL_SAMPLES));
    status_o.cal_any     = (cal_valid_q != '0);
    status_o.win_done    = (win_index_q >= win_len);
    status_o.win_fail    = (win_valid_q == '0) || (win_valid_q < (win_len >> 1));
    status_o.div_done    = div_done;
    status_o.sqrt_done   = sqrt_done;
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
